/* src/scp_pkg.sv */
package scp_pkg;

    // field widths
    localparam int ANGLE_W    = 32;
    localparam int OUT_W      = 18;

    // range reduction
    localparam int MAG_W      = 32;
    localparam int INV_W      = 30;
    localparam int PROD_W     = MAG_W + INV_W;
    localparam int TURN_SH    = 56;
    localparam int TURN_W     = PROD_W - TURN_SH;
    localparam int RED_W      = 28;
    localparam int Y_W        = 27;

    // polynomial datapath
    localparam int Y2_W       = 27;
    localparam int T_W        = 32;
    localparam int FRAC_SH    = 24;
    localparam int SIN_SH     = 38;
    localparam int SIN_W      = 20;
    localparam int COS_SH     = 14;
    localparam int COS_W      = 19;

    localparam int NUM_STAGES = 16;

    // 1/(2*pi) in Q0.32; 2*pi, pi, pi/2 in Q8.24
    localparam logic [INV_W-1:0]        Q_INV2PI = 30'd683565275;
    localparam logic signed [RED_W-1:0] Q_2PI    = 28'sd105414357;
    localparam logic signed [RED_W-1:0] Q_PI     = 28'sd52707179;
    localparam logic signed [RED_W-1:0] Q_PIDIV2 = 28'sd26353589;

    // Horner coefficients, Q2.30, with their signs folded in
    localparam logic signed [T_W-1:0] Q_ONE    = 32'sd1073741824;
    localparam logic signed [T_W-1:0] S_C7_NEG = -32'sd198907;
    localparam logic signed [T_W-1:0] S_C5     = 32'sd8927036;
    localparam logic signed [T_W-1:0] S_C3_NEG = -32'sd178948223;
    localparam logic signed [T_W-1:0] C_C6_NEG = -32'sd1364987;
    localparam logic signed [T_W-1:0] C_C4     = 32'sd44553756;
    localparam logic signed [T_W-1:0] C_C2_NEG = -32'sd536793023;

    localparam logic signed [SIN_W-1:0] OUT_MAX = 20'sd65536;

    // load enables for a two-stage multiply/round unit
    typedef struct packed {
        logic prod;
        logic sum;
    } scp_ld_t;

endpackage

/* src/sin_cos_minimax_poly_core.sv */
// Sine and cosine of a Q8.24 angle, results in Q1.16 saturated to +-1.0.
// Throughput: one item per cycle while the output is not stalled; each of the 16 stages has its own valid bit
// and stalls only when the stage after it is full and stalled, so bubbles close up.
// Reset (aresetn, synchronous, active low) clears the valid bits only;
// data registers are not reset.
module sin_cos_minimax_poly_core import scp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [ANGLE_W-1:0] s_angle,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_sine,
    output logic signed [OUT_W-1:0]  m_cosine
);

    localparam int RW2 = ANGLE_W + 2;
    localparam logic [PROD_W-1:0] TURN_HALF = PROD_W'(1) << (TURN_SH - 1);
    localparam logic [T_W:0]      COS_HALF  = (T_W + 1)'(1) << (COS_SH - 1);

    // ---------------------------------------------------------------
    // Stage control: stage i loads when it is empty or its successor
    // is moving. The last stage is the output register.
    // ---------------------------------------------------------------
    logic [NUM_STAGES:1] valid_reg, valid_next;
    logic [NUM_STAGES:1] stage_rdy;
    logic [NUM_STAGES:1] stage_ld;

    always_comb begin
        stage_rdy[NUM_STAGES] = !valid_reg[NUM_STAGES] || m_ready;
        for (int i = NUM_STAGES - 1; i >= 1; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        stage_ld[1]   = stage_rdy[1] && s_valid;
        valid_next[1] = stage_rdy[1] ? s_valid : valid_reg[1];
        for (int i = 2; i <= NUM_STAGES; i++) begin
            stage_ld[i]   = stage_rdy[i] && valid_reg[i-1];
            valid_next[i] = stage_rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_rdy[1];
    assign m_valid = valid_reg[NUM_STAGES];

    // ---------------------------------------------------------------
    // Range reduction
    // ---------------------------------------------------------------
    // stage 1: magnitude and sign
    logic signed [ANGLE_W-1:0] a1_reg, a2_reg, a3_reg;
    logic                      neg1_reg, neg2_reg;
    logic [MAG_W-1:0]          mag1_reg, mag1_next;
    // stage 2: |angle| * 1/(2*pi)
    logic [PROD_W-1:0]         prod2_reg, prod2_next;
    // stage 3: rounded, signed turn count
    logic signed [TURN_W-1:0]  turns3_reg, turns3_next;
    logic [PROD_W-1:0]         turn_sum;
    logic [TURN_W-1:0]         turn_mag;
    // stage 4: angle minus whole turns
    logic signed [RED_W-1:0]   y4_reg, y4_next;
    logic signed [RW2-1:0]     a_x, turns_x, twopi_x, y_full;
    // stage 5: fold into [-pi/2, pi/2]
    logic signed [RED_W-1:0]   fold_full;
    logic signed [Y_W-1:0]     y5_next;
    logic                      flip5_next;

    assign mag1_next = s_angle[ANGLE_W-1] ? (MAG_W'(0) - MAG_W'($unsigned(s_angle)))
                                          : MAG_W'($unsigned(s_angle));
    assign prod2_next = PROD_W'(mag1_reg) * PROD_W'(Q_INV2PI);

    always_comb begin
        turn_sum    = prod2_reg + TURN_HALF;
        turn_mag    = turn_sum[TURN_SH +: TURN_W];
        turns3_next = neg2_reg ? -$signed(turn_mag) : $signed(turn_mag);
    end

    always_comb begin
        a_x     = RW2'(a3_reg);
        turns_x = RW2'(turns3_reg);
        twopi_x = RW2'(Q_2PI);
        y_full  = a_x - turns_x * twopi_x;
        y4_next = y_full[RED_W-1:0];
    end

    always_comb begin
        fold_full  = y4_reg;
        flip5_next = 1'b0;
        if (y4_reg > Q_PIDIV2) begin
            fold_full  = Q_PI - y4_reg;
            flip5_next = 1'b1;
        end else if (y4_reg < -Q_PIDIV2) begin
            fold_full  = -Q_PI - y4_reg;
            flip5_next = 1'b1;
        end
        y5_next = fold_full[Y_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[1]) begin
            a1_reg   <= s_angle;
            neg1_reg <= s_angle[ANGLE_W-1];
            mag1_reg <= mag1_next;
        end
        if (stage_ld[2]) begin
            a2_reg    <= a1_reg;
            neg2_reg  <= neg1_reg;
            prod2_reg <= prod2_next;
        end
        if (stage_ld[3]) begin
            a3_reg     <= a2_reg;
            turns3_reg <= turns3_next;
        end
        if (stage_ld[4]) begin
            y4_reg <= y4_next;
        end
    end

    // ---------------------------------------------------------------
    // Side lines: folded angle, its square and the cosine flip travel
    // alongside the polynomial stages.
    // ---------------------------------------------------------------
    logic signed [Y_W-1:0]  y_pipe_reg    [5:13];
    logic signed [Y2_W-1:0] y2_pipe_reg   [8:11];
    logic                   flip_pipe_reg [5:15];
    logic signed [Y2_W-1:0] y2_7;

    always_ff @(posedge aclk) begin
        if (stage_ld[5]) begin
            y_pipe_reg[5]    <= y5_next;
            flip_pipe_reg[5] <= flip5_next;
        end
        for (int i = 6; i <= 13; i++) begin
            if (stage_ld[i]) begin
                y_pipe_reg[i] <= y_pipe_reg[i-1];
            end
        end
        for (int i = 6; i <= 15; i++) begin
            if (stage_ld[i]) begin
                flip_pipe_reg[i] <= flip_pipe_reg[i-1];
            end
        end
        if (stage_ld[8]) begin
            y2_pipe_reg[8] <= y2_7;
        end
        for (int i = 9; i <= 11; i++) begin
            if (stage_ld[i]) begin
                y2_pipe_reg[i] <= y2_pipe_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 6-7: y^2 back to Q.24
    // ---------------------------------------------------------------
    scp_mul_round #(
        .A_W(Y_W), .B_W(Y_W), .SHIFT(FRAC_SH), .R_W(Y2_W)
    ) u_square (
        .aclk   (aclk),
        .ld     ('{prod: stage_ld[6], sum: stage_ld[7]}),
        .op_a   (y_pipe_reg[5]),
        .op_b   (y_pipe_reg[5]),
        .addend ('0),
        .result (y2_7)
    );

    // ---------------------------------------------------------------
    // Stages 8-13: three Horner steps per lane, two stages each
    // ---------------------------------------------------------------
    logic signed [T_W-1:0] ts1, ts2, ts3;
    logic signed [T_W-1:0] tc1, tc2, tc3;

    scp_mul_round #(
        .A_W(T_W), .B_W(Y2_W), .SHIFT(FRAC_SH), .R_W(T_W)
    ) u_sin_h1 (
        .aclk   (aclk),
        .ld     ('{prod: stage_ld[8], sum: stage_ld[9]}),
        .op_a   (S_C7_NEG),
        .op_b   (y2_7),
        .addend (S_C5),
        .result (ts1)
    );

    scp_mul_round #(
        .A_W(T_W), .B_W(Y2_W), .SHIFT(FRAC_SH), .R_W(T_W)
    ) u_sin_h2 (
        .aclk   (aclk),
        .ld     ('{prod: stage_ld[10], sum: stage_ld[11]}),
        .op_a   (ts1),
        .op_b   (y2_pipe_reg[9]),
        .addend (S_C3_NEG),
        .result (ts2)
    );

    scp_mul_round #(
        .A_W(T_W), .B_W(Y2_W), .SHIFT(FRAC_SH), .R_W(T_W)
    ) u_sin_h3 (
        .aclk   (aclk),
        .ld     ('{prod: stage_ld[12], sum: stage_ld[13]}),
        .op_a   (ts2),
        .op_b   (y2_pipe_reg[11]),
        .addend (Q_ONE),
        .result (ts3)
    );

    scp_mul_round #(
        .A_W(T_W), .B_W(Y2_W), .SHIFT(FRAC_SH), .R_W(T_W)
    ) u_cos_h1 (
        .aclk   (aclk),
        .ld     ('{prod: stage_ld[8], sum: stage_ld[9]}),
        .op_a   (C_C6_NEG),
        .op_b   (y2_7),
        .addend (C_C4),
        .result (tc1)
    );

    scp_mul_round #(
        .A_W(T_W), .B_W(Y2_W), .SHIFT(FRAC_SH), .R_W(T_W)
    ) u_cos_h2 (
        .aclk   (aclk),
        .ld     ('{prod: stage_ld[10], sum: stage_ld[11]}),
        .op_a   (tc1),
        .op_b   (y2_pipe_reg[9]),
        .addend (C_C2_NEG),
        .result (tc2)
    );

    scp_mul_round #(
        .A_W(T_W), .B_W(Y2_W), .SHIFT(FRAC_SH), .R_W(T_W)
    ) u_cos_h3 (
        .aclk   (aclk),
        .ld     ('{prod: stage_ld[12], sum: stage_ld[13]}),
        .op_a   (tc2),
        .op_b   (y2_pipe_reg[11]),
        .addend (Q_ONE),
        .result (tc3)
    );

    // ---------------------------------------------------------------
    // Stages 14-15: scale to Q1.16
    // sine = poly * y >> 38, cosine = poly >> 14, both rounded half away
    // ---------------------------------------------------------------
    logic signed [SIN_W-1:0] s15;
    logic signed [T_W-1:0]   tc14_reg;
    logic signed [COS_W-1:0] c15_reg, c15_next;
    logic [T_W:0]            cos_sum;

    scp_mul_round #(
        .A_W(T_W), .B_W(Y_W), .SHIFT(SIN_SH), .R_W(SIN_W)
    ) u_sin_scale (
        .aclk   (aclk),
        .ld     ('{prod: stage_ld[14], sum: stage_ld[15]}),
        .op_a   (ts3),
        .op_b   (y_pipe_reg[13]),
        .addend ('0),
        .result (s15)
    );

    always_comb begin
        cos_sum  = (T_W + 1)'(tc14_reg) + COS_HALF - (T_W + 1)'(tc14_reg[T_W-1]);
        c15_next = cos_sum[COS_SH +: COS_W];
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[14]) begin
            tc14_reg <= tc3;
        end
        if (stage_ld[15]) begin
            c15_reg <= c15_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 16: cosine sign flip, saturation, output register
    // ---------------------------------------------------------------
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SIN_W-1:0] v);
        logic signed [SIN_W-1:0] lim;
        lim = v;
        if (v > OUT_MAX) begin
            lim = OUT_MAX;
        end else if (v < -OUT_MAX) begin
            lim = -OUT_MAX;
        end
        return lim[OUT_W-1:0];
    endfunction

    logic signed [SIN_W-1:0] c_ext, c_signed;
    logic signed [OUT_W-1:0] sine_reg, sine_next, cosine_reg, cosine_next;

    always_comb begin
        c_ext       = SIN_W'(c15_reg);
        c_signed    = flip_pipe_reg[15] ? -c_ext : c_ext;
        sine_next   = sat_out(s15);
        cosine_next = sat_out(c_signed);
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[16]) begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign m_sine   = sine_reg;
    assign m_cosine = cosine_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // results never leave the saturated range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sine <= OUT_MAX && m_sine >= -OUT_MAX &&
                     m_cosine <= OUT_MAX && m_cosine >= -OUT_MAX))
        else $error("result outside +-1.0");

    // folded angle lies within [-pi/2, pi/2]
    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[5] |-> (y_pipe_reg[5] <= Q_PIDIV2 && y_pipe_reg[5] >= -Q_PIDIV2))
        else $error("folded angle out of range");

    // input stalls only when every stage holds an item
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> &valid_reg)
        else $error("input stalled with a free stage");

    // a stalled output item is still there, unchanged, next cycle
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sine) && $stable(m_cosine)))
        else $error("output item lost under stall");

endmodule

/* src/scp_mul_round.sv */
// Two register stages: product, then round half away from zero plus addend.
module scp_mul_round import scp_pkg::*; #(
    parameter int A_W   = T_W,
    parameter int B_W   = Y2_W,
    parameter int SHIFT = FRAC_SH,
    parameter int R_W   = T_W
) (
    input  logic                  aclk,
    input  scp_ld_t               ld,
    input  logic signed [A_W-1:0] op_a,
    input  logic signed [B_W-1:0] op_b,
    input  logic signed [R_W-1:0] addend,
    output logic signed [R_W-1:0] result
);

    localparam int P_W = A_W + B_W;
    localparam int S_W = P_W + 2;
    localparam logic [S_W-1:0] HALF = S_W'(1) << (SHIFT - 1);

    logic signed [P_W-1:0] prod_reg, prod_next;
    logic signed [R_W-1:0] result_reg, result_next;
    logic [S_W-1:0]        prod_x, add_x, sum_full;

    assign prod_next = P_W'(op_a) * P_W'(op_b);

    // negative products round with half minus one, then floor: half away from zero
    always_comb begin
        prod_x      = S_W'(prod_reg);
        add_x       = S_W'(addend) << SHIFT;
        sum_full    = prod_x + add_x + HALF - S_W'(prod_reg[P_W-1]);
        result_next = sum_full[SHIFT +: R_W];
    end

    always_ff @(posedge aclk) begin
        if (ld.prod) begin
            prod_reg <= prod_next;
        end
        if (ld.sum) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
